// ===== hw/rtl/atc2d_pkg.sv =====
// Package: shared constants, types and tables for the 2D affine composer.
`timescale 1ns / 1ps
package atc2d_pkg;
  localparam int FracBits    = 16;
  localparam int CordicSteps = 16;
  localparam int AtanEntries = 24;
  localparam int NumSteps    = (CordicSteps > AtanEntries) ? AtanEntries : CordicSteps;
  localparam int StepW       = $clog2(AtanEntries + 1);
  localparam logic signed [63:0] OneFx = 64'sd1 <<< FracBits;
  localparam logic signed [63:0] CordicGain = 64'sd652032874;

  typedef enum logic [2:0] {
    OP_IDENTITY  = 3'd0,
    OP_TRANSLATE = 3'd1,
    OP_ROTATE    = 3'd2,
    OP_SCALE     = 3'd3,
    OP_SHEAR     = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_REDUCE, ST_SEED, ST_CORDIC, ST_MAC, ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input word
    logic reduce;    // one compare-subtract step of the angle reduction
    logic seed;      // fold the angle and start CORDIC
    logic cordic;    // one CORDIC iteration
    logic mac;       // one half product of an entry
    logic commit;    // write new matrix and result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic reduce_done;
    logic cordic_done;
    logic mac_done;
  } status_t;

  function automatic logic signed [39:0] atan_ndeg(input logic [StepW-1:0] i);
    logic signed [39:0] v;
    v = '0;
    unique case (i)
      5'd0:  v = 40'sd45000000000;
      5'd1:  v = 40'sd26565051177;
      5'd2:  v = 40'sd14036243468;
      5'd3:  v = 40'sd7125016349;
      5'd4:  v = 40'sd3576334375;
      5'd5:  v = 40'sd1789910608;
      5'd6:  v = 40'sd895173710;
      5'd7:  v = 40'sd447614171;
      5'd8:  v = 40'sd223810500;
      5'd9:  v = 40'sd111905677;
      5'd10: v = 40'sd55952892;
      5'd11: v = 40'sd27976453;
      5'd12: v = 40'sd13988227;
      5'd13: v = 40'sd6994114;
      5'd14: v = 40'sd3497057;
      5'd15: v = 40'sd1748528;
      5'd16: v = 40'sd874264;
      5'd17: v = 40'sd437132;
      5'd18: v = 40'sd218566;
      5'd19: v = 40'sd109283;
      5'd20: v = 40'sd54642;
      5'd21: v = 40'sd27321;
      5'd22: v = 40'sd13660;
      5'd23: v = 40'sd6830;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage

// ===== hw/rtl/atc2d_ctrl.sv =====
// Controller: sequences capture, angle reduction, CORDIC, products and output.
`timescale 1ns / 1ps
module atc2d_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic                is_rotate,
  input  logic                out_fire,
  input  atc2d_pkg::status_t  status,
  output atc2d_pkg::cmd_t     cmd,
  output logic                busy,
  output logic                out_valid
);
  atc2d_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= atc2d_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      atc2d_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = is_rotate ? atc2d_pkg::ST_REDUCE : atc2d_pkg::ST_MAC;
        end
      end
      atc2d_pkg::ST_REDUCE: begin
        cmd.reduce = 1'b1;
        if (status.reduce_done) state_next = atc2d_pkg::ST_SEED;
      end
      atc2d_pkg::ST_SEED: begin
        cmd.seed = 1'b1;
        state_next = atc2d_pkg::ST_CORDIC;
      end
      atc2d_pkg::ST_CORDIC: begin
        cmd.cordic = 1'b1;
        if (status.cordic_done) state_next = atc2d_pkg::ST_MAC;
      end
      atc2d_pkg::ST_MAC: begin
        cmd.mac = 1'b1;
        if (status.mac_done) begin
          cmd.commit = 1'b1;
          state_next = atc2d_pkg::ST_OUT;
        end
      end
      atc2d_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_fire) state_next = atc2d_pkg::ST_IDLE;
      end
      default: state_next = atc2d_pkg::ST_IDLE;
    endcase
  end
endmodule

// ===== hw/rtl/atc2d_dp.sv =====
// Datapath: operand registers, angle reduction, CORDIC, shared MAC, matrix store.
`timescale 1ns / 1ps
module atc2d_dp (
  input  logic                clk,
  input  logic                rst,
  input  atc2d_pkg::cmd_t     cmd,
  input  logic [2:0]          operation,
  input  logic signed [31:0]  operand_a,
  input  logic signed [31:0]  operand_b,
  output atc2d_pkg::status_t  status,
  output logic [199:0]        result
);
  localparam int Sh = 30 - atc2d_pkg::FracBits;

  // angle reduction constants: an offset of whole turns makes the angle
  // non-negative, then a restoring subtract of shifted turns leaves the remainder
  localparam longint FullTurnL = 64'sd360 <<< atc2d_pkg::FracBits;
  localparam longint RedMult   = (64'sd2147483648 + FullTurnL - 64'sd1) / FullTurnL;
  localparam int     RedSteps  = $clog2(2 * RedMult);
  localparam int     RedW      = $clog2(RedSteps + 1);
  localparam logic signed [40:0] FullTurn    = 41'(FullTurnL);
  localparam logic signed [40:0] RedOffset   = 41'(RedMult * FullTurnL);
  localparam logic signed [40:0] HalfTurn    = FullTurn >>> 1;
  localparam logic signed [40:0] QuarterTurn = FullTurn >>> 2;

  logic [2:0]         op;
  logic signed [31:0] a, b;
  logic signed [31:0] m [6];
  logic signed [31:0] n [6];
  logic               sat;
  logic signed [31:0] c, s;

  // CORDIC registers
  logic signed [33:0] cx, cy;
  logic signed [39:0] cz;
  logic               flip;
  logic [atc2d_pkg::StepW-1:0] step;

  // product sequencing: two half products per entry
  logic [2:0]         ent;
  logic               half;
  logic signed [63:0] p1;

  // angle reduction: ang walks down to a mod 360, then fold to +-90
  logic signed [40:0] ang, ang_sub, r, rr;
  logic [RedW-1:0]    rbit;
  logic signed [63:0] rn;
  logic               fl;
  always_comb begin
    ang_sub = FullTurn <<< rbit;
    r = ang;
    if (r >= HalfTurn) r = r - FullTurn;
    fl = 1'b0;
    rr = r;
    if (r > QuarterTurn) begin
      rr = r - HalfTurn; fl = 1'b1;
    end else if (r < -QuarterTurn) begin
      rr = r + HalfTurn; fl = 1'b1;
    end
    rn = 64'(32'(rr)) * 64'sd1000000000;
  end

  // factor selection for the current product
  logic signed [31:0] fa, fb;
  logic [1:0] col;
  logic       row1;
  logic [2:0] idx0, idx1;
  always_comb begin
    col  = (ent >= 3'd3) ? 2'(ent - 3'd3) : ent[1:0];
    row1 = (ent >= 3'd3);
    idx0 = {1'b0, col};
    idx1 = {1'b0, col} + 3'd3;
    fa = '0; fb = '0;
    unique case (op)
      atc2d_pkg::OP_TRANSLATE: begin
        if (col == 2'd2) begin
          fa = half ? (row1 ? b : a) : (row1 ? m[5] : m[2]);
          fb = 32'(atc2d_pkg::OneFx);
        end
      end
      atc2d_pkg::OP_ROTATE: begin
        fa = half ? (row1 ? c : -s) : (row1 ? s : c);
        fb = half ? m[idx1] : m[idx0];
      end
      atc2d_pkg::OP_SCALE: begin
        if (!half) begin
          fa = row1 ? b : a;
          fb = row1 ? m[idx1] : m[idx0];
        end
      end
      atc2d_pkg::OP_SHEAR: begin
        fa = half ? (row1 ? 32'(atc2d_pkg::OneFx) : a) : (row1 ? b : 32'(atc2d_pkg::OneFx));
        fb = half ? m[idx1] : m[idx0];
      end
      default: ;
    endcase
  end

  logic signed [63:0] prod;
  assign prod = 64'(fa) * 64'(fb);

  // combine: floor parts plus summed fractions with round half up
  logic signed [63:0] hi, lo, sum;
  logic [63:0] mask;
  always_comb begin
    mask = (64'd1 << atc2d_pkg::FracBits) - 64'd1;
    hi  = (p1 >>> atc2d_pkg::FracBits) + (prod >>> atc2d_pkg::FracBits);
    lo  = 64'((p1 & mask) + (prod & mask)) + (64'sd1 <<< (atc2d_pkg::FracBits - 1));
    sum = hi + (lo >>> atc2d_pkg::FracBits);
  end

  logic touched;
  always_comb begin
    unique case (op)
      atc2d_pkg::OP_TRANSLATE: touched = (col == 2'd2);
      atc2d_pkg::OP_ROTATE, atc2d_pkg::OP_SCALE, atc2d_pkg::OP_SHEAR: touched = 1'b1;
      default: touched = 1'b0;
    endcase
  end

  logic signed [33:0] xs, ys;
  logic signed [34:0] cr, sr;
  assign xs = cx >>> step;
  assign ys = cy >>> step;
  assign cr = (35'(cx) + (35'sd1 <<< (Sh - 1))) >>> Sh;
  assign sr = (35'(cy) + (35'sd1 <<< (Sh - 1))) >>> Sh;

  assign status.reduce_done = (rbit == '0);
  assign status.cordic_done = (step == atc2d_pkg::StepW'(atc2d_pkg::NumSteps - 1));
  assign status.mac_done    = (ent == 3'd5) && half;

  always_ff @(posedge clk) begin
    if (rst) begin
      m[0] <= 32'(atc2d_pkg::OneFx); m[1] <= '0; m[2] <= '0;
      m[3] <= '0; m[4] <= 32'(atc2d_pkg::OneFx); m[5] <= '0;
      step <= '0; ent <= '0; half <= 1'b0; sat <= 1'b0;
    end else begin
      if (cmd.load) begin
        op <= operation; a <= operand_a; b <= operand_b;
        ent <= '0; half <= 1'b0; sat <= 1'b0;
        ang <= 41'(operand_a) + RedOffset;
        rbit <= RedW'(RedSteps - 1);
        for (int k = 0; k < 6; k++) n[k] <= m[k];
        if (operation == atc2d_pkg::OP_IDENTITY) begin
          n[0] <= 32'(atc2d_pkg::OneFx); n[1] <= '0; n[2] <= '0;
          n[3] <= '0; n[4] <= 32'(atc2d_pkg::OneFx); n[5] <= '0;
        end
      end
      // one quotient bit per cycle, highest first
      if (cmd.reduce) begin
        if (ang >= ang_sub) ang <= ang - ang_sub;
        rbit <= rbit - 1'b1;
      end
      if (cmd.seed) begin
        cx <= 34'(atc2d_pkg::CordicGain); cy <= '0;
        cz <= 40'(rn >>> atc2d_pkg::FracBits);
        flip <= fl; step <= '0;
      end
      if (cmd.cordic) begin
        if (cz >= 0) begin
          cx <= cx - ys; cy <= cy + xs; cz <= cz - atc2d_pkg::atan_ndeg(step);
        end else begin
          cx <= cx + ys; cy <= cy - xs; cz <= cz + atc2d_pkg::atan_ndeg(step);
        end
        step <= step + 1'b1;
      end
      if (cmd.mac) begin
        if (!half) begin
          p1 <= prod;
        end else begin
          if (touched) begin
            if (sum > 64'sd2147483647) begin
              n[ent] <= 32'h7fffffff; sat <= 1'b1;
            end else if (sum < -64'sd2147483648) begin
              n[ent] <= 32'h80000000; sat <= 1'b1;
            end else n[ent] <= 32'(sum);
          end
          ent <= ent + 3'd1;
        end
        half <= ~half;
      end
      if (cmd.commit) begin
        for (int k = 0; k < 6; k++) if (k != 5) m[k] <= n[k];
        if (touched) begin
          if (sum > 64'sd2147483647) m[5] <= 32'h7fffffff;
          else if (sum < -64'sd2147483648) m[5] <= 32'h80000000;
          else m[5] <= 32'(sum);
        end else m[5] <= n[5];
      end
    end
  end

  // cosine and sine from the CORDIC result, sign fixed by the fold
  assign c = flip ? -32'(cr) : 32'(cr);
  assign s = flip ? -32'(sr) : 32'(sr);

  assign result = {7'd0, sat, m[5], m[4], m[3], m[2], m[1], m[0]};
endmodule

// ===== hw/rtl/affine_transform_composer_2d.sv =====
// Top level: 2D affine transform composer with stream ports.
`timescale 1ns / 1ps
// Keeps a 2D affine matrix in Q16.16 and pre-multiplies it by one elementary
// transform per input word, returning the six entries and a saturation flag.
// One word at a time: for translate, scale, shear, identity and unused codes
// the result word is offered once the products are done (six entries, two
// products each through one shared multiplier). Rotate first adds the angle
// reduction, a fold of the angle and 16 CORDIC steps before the products. The
// next word is taken only once the result has been read, so an output stall
// also holds off the next input word.
module affine_transform_composer_2d (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [71:0]  s_tdata,   // operation[2:0], operand_a[34:3], operand_b[66:35]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [199:0] m_tdata    // m00, m01, m02, m10, m11, m12 (32 each), saturated[192]
);
  atc2d_pkg::cmd_t    cmd;
  atc2d_pkg::status_t status;
  logic busy, in_fire;

  assign s_tready = ~busy;
  assign in_fire  = s_tvalid & s_tready;

  atc2d_ctrl u_ctrl (
    .clk, .rst, .in_fire,
    .is_rotate(s_tdata[2:0] == atc2d_pkg::OP_ROTATE),
    .out_fire(m_tvalid & m_tready),
    .status, .cmd, .busy, .out_valid(m_tvalid)
  );

  atc2d_dp u_dp (
    .clk, .rst, .cmd,
    .operation(s_tdata[2:0]),
    .operand_a(s_tdata[34:3]),
    .operand_b(s_tdata[66:35]),
    .status, .result(m_tdata)
  );
endmodule
